FILE: hw/rtl/sked_pkg.sv
// Shared types, codes and key tables of the serial key event decoder.
// Used by sked_keys, sked_emit and serial_key_event_decoder; depends on nothing.
package sked_pkg;

	localparam int NUM_KEYS   = 6;
	localparam int TABLE_KEYS = 6;
	localparam int KEY_W      = 3;
	localparam int KIND_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd80;

	localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELALL = 2'd2;

	// Trigger bytes: up, down, left, right, space, escape.
	localparam logic [BYTE_W-1:0] PRESS_BYTE [TABLE_KEYS] = '{
		8'h57, 8'h53, 8'h41, 8'h44, 8'h20, 8'h51
	};
	localparam logic [BYTE_W-1:0] RELEASE_BYTE [TABLE_KEYS] = '{
		8'h77, 8'h73, 8'h61, 8'h64, 8'h20, 8'h71
	};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] byte_value;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0] mask;
		logic                press;
	} ev_t;

endpackage

FILE: hw/rtl/sked_keys.sv
// Key state (held flags and last-seen times) and the per-item event decision.
// Depends on sked_pkg.
module sked_keys (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sked_pkg::item_t              item,
	input  logic                         item_valid,
	input  logic                         commit,
	input  logic [sked_pkg::TMO_W-1:0]   timeout,
	output sked_pkg::ev_t                ev
);

	logic [sked_pkg::NUM_KEYS-1:0]     held_q;
	logic [sked_pkg::TIME_W-1:0]       last_seen_q [sked_pkg::NUM_KEYS];
	logic [sked_pkg::NUM_KEYS-1:0]     press_hit;
	logic [sked_pkg::NUM_KEYS-1:0]     release_hit;
	logic [sked_pkg::NUM_KEYS-1:0]     aged;
	logic [sked_pkg::TIME_W-1:0]       age [sked_pkg::NUM_KEYS];
	logic                              found;

	// Byte match: the first key whose press or release byte matches wins.
	always_comb begin
		press_hit   = '0;
		release_hit = '0;
		found       = 1'b0;
		for (int i = 0; i < sked_pkg::NUM_KEYS; i++) begin
			if (!found) begin
				if (item.byte_value == sked_pkg::PRESS_BYTE[i]) begin
					press_hit[i] = 1'b1;
					found        = 1'b1;
				end else if (item.byte_value == sked_pkg::RELEASE_BYTE[i] &&
				             sked_pkg::RELEASE_BYTE[i] != sked_pkg::PRESS_BYTE[i]) begin
					release_hit[i] = 1'b1;
					found          = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < sked_pkg::NUM_KEYS; i++) begin
			age[i]  = item.now_ms - last_seen_q[i];
			aged[i] = age[i] >= {{(sked_pkg::TIME_W-sked_pkg::TMO_W){1'b0}}, timeout};
		end
	end

	always_comb begin
		ev.press = 1'b0;
		ev.mask  = '0;
		unique case (item.kind)
			sked_pkg::KIND_BYTE: begin
				ev.mask  = (press_hit & ~held_q) | (release_hit & held_q);
				ev.press = |(press_hit & ~held_q);
			end
			sked_pkg::KIND_CHECK:  ev.mask = held_q & aged;
			sked_pkg::KIND_RELALL: ev.mask = held_q;
			default:               ev.mask = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < sked_pkg::NUM_KEYS; i++) begin
				last_seen_q[i] <= '0;
			end
		end else if (commit) begin
			if (item.kind == sked_pkg::KIND_BYTE) begin
				held_q <= (held_q | press_hit) & ~release_hit;
				for (int i = 0; i < sked_pkg::NUM_KEYS; i++) begin
					if (press_hit[i]) begin
						last_seen_q[i] <= item.now_ms;
					end
				end
			end else begin
				held_q <= held_q & ~ev.mask;
			end
		end
	end

`ifndef ASSERT_OFF
	a_byte_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.kind == sked_pkg::KIND_BYTE |-> $onehot0(ev.mask))
		else $error("byte item caused more than one event");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> item_valid)
		else $error("state committed without a registered item");
`endif

endmodule

FILE: hw/rtl/sked_emit.sv
// Event buffer that hands out one event per cycle while out_ready is high, lowest key first.
// Depends on sked_pkg.
module sked_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  sked_pkg::ev_t                ev,
	output logic                         free,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sked_pkg::KEY_W-1:0]   out_key,
	output logic                         out_press,
	output logic                         out_last
);

	logic [sked_pkg::NUM_KEYS-1:0] mask_q;
	logic                          press_q;
	logic [sked_pkg::NUM_KEYS-1:0] rest;
	logic                          pop;

	assign rest      = mask_q & (mask_q - 1'b1);
	assign out_valid = |mask_q;
	assign out_last  = out_valid && (rest == '0);
	assign out_press = press_q;
	assign pop       = out_valid && out_ready;
	assign free      = !out_valid || (pop && out_last);

	always_comb begin
		out_key = '0;
		for (int i = sked_pkg::NUM_KEYS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				out_key = sked_pkg::KEY_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= ev.mask;
		end else if (pop) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			press_q <= ev.press;
		end
	end

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("event buffer overwritten while events were pending");
	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && out_last && !load |=> !out_valid)
		else $error("event remained after the last one was taken");
`endif

endmodule

FILE: hw/rtl/serial_key_event_decoder.sv
// Top level of the serial key event decoder: input register, timeout register,
// handshake control. Depends on sked_pkg, sked_keys and sked_emit.

// The decoder takes one item per cycle on the slave stream while s_tready is high
// and turns it into key press and release events for six keys (up, down, left,
// right, space, escape). Each accepted item is registered, decided against the
// current key state, and its events are then placed in an event buffer that hands
// them out one per cycle on the master stream while m_tready is high, in ascending
// key order, with tlast on the last event of the item. Items that cause no event
// or a single event flow back to back while m_tready stays high; an item that
// releases several keys at once (a timeout check or a release-all) puts one event
// per key in the buffer, and the next item that has events waits in the input
// register until the buffer is drained. The release timeout is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which the
// block does not enforce, and it resets to 80 ms.
module serial_key_event_decoder (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // release_timeout

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,       // [7:0] byte_value, [39:8] now_ms
	input  logic [1:0]  s_tuser,       // [1:0] kind

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // [2:0] key_index, [7:3] zero
	output logic        m_tuser,       // [0] is_press
	output logic        m_tlast        // last_event
);

	logic [sked_pkg::TMO_W-1:0]  timeout_q;
	sked_pkg::item_t             item_s1;
	logic                        valid_s1;
	sked_pkg::ev_t               ev;
	logic                        buf_free;
	logic                        advance;
	logic                        load;
	logic [sked_pkg::KEY_W-1:0]  key;

	// The registered item moves on once its events, if any, fit in the buffer.
	assign advance  = valid_s1 && ((ev.mask == '0) || buf_free);
	assign load     = advance && (ev.mask != '0);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sked_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// The item payload needs no reset; it is only looked at while valid_s1 is set.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind       <= s_tuser;
			item_s1.byte_value <= s_tdata[7:0];
			item_s1.now_ms     <= s_tdata[39:8];
		end
	end

	sked_keys u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.item_valid (valid_s1),
		.commit     (advance),
		.timeout    (timeout_q),
		.ev         (ev)
	);

	sked_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ev        (ev),
		.free      (buf_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_key   (key),
		.out_press (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'b0, key};

`ifndef ASSERT_OFF
	a_wait_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled item was lost or changed");
`endif

endmodule
